// ===== rtl/complex_gain_row_dot_product_top_assert.svh =====
// Assertion macros shared by the files that check the block's own logic.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef COMPLEX_GAIN_ROW_DOT_PRODUCT_TOP_ASSERT_SVH
`define COMPLEX_GAIN_ROW_DOT_PRODUCT_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CGRDP_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: trig implies cond");

// The condition must hold in the cycle after the trigger.
`define CGRDP_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: trig implies cond next cycle");

`endif

// ===== rtl/cgrdp_pkg.sv =====
package cgrdp_pkg;

    localparam int MAX_ANTENNAS  = 64;
    localparam int POLARIZATIONS = 4;
    localparam int MAX_TIMESTEPS = 1024;

    localparam int ANT_W = $clog2(MAX_ANTENNAS);
    localparam int POL_W = $clog2(POLARIZATIONS);

    // Field widths of the transactions and registers.
    localparam int FIELD_ANT_W = 6;
    localparam int FIELD_POL_W = 2;
    localparam int COEF_W      = 16;
    localparam int SUM_OUT_W   = 20;
    localparam int CFG_NA_W    = 7;
    localparam int CFG_NT_W    = 11;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam int ROWS_MAX = (MAX_ANTENNAS - 1) * MAX_TIMESTEPS * POLARIZATIONS;
    localparam int ROW_W    = $clog2(ROWS_MAX + 1);
    localparam int GEOM_PROD_W = CFG_NA_W + CFG_NT_W;

    // Datapath widths: exact products, lane sums and the four-lane total.
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int LANE_W    = PROD_W + 1;
    localparam int ACC_W     = LANE_W + POL_W + 1;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_BITS - 1));

    typedef enum logic
    {
        ACT_LOAD    = 1'b0,
        ACT_COMPUTE = 1'b1
    } action_t;

    typedef enum logic
    {
        REG_ANTENNAS  = 1'b0,
        REG_TIMESTEPS = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
    } cplx_t;

    typedef cplx_t [POLARIZATIONS-1:0] lanes_t;

    // Clamped geometry of the data vector.
    typedef struct packed
    {
        logic [CFG_NA_W-1:0] na;
        logic [ROW_W-1:0]    rows;
    } geom_t;

    // Sideband of one row: antenna used and end-of-vector mark.
    typedef struct packed
    {
        logic [ANT_W-1:0] antenna;
        logic             last;
    } row_tag_t;

endpackage

// ===== rtl/cgrdp_in_if.sv =====
interface cgrdp_in_if;
    import cgrdp_pkg::*;

    logic                     valid;
    logic                     ready;
    action_t                  action;
    logic [FIELD_ANT_W-1:0]   gain_antenna;
    logic [FIELD_POL_W-1:0]   gain_polarization;
    logic signed [COEF_W-1:0] coef0_re;
    logic signed [COEF_W-1:0] coef0_im;
    logic signed [COEF_W-1:0] coef1_re;
    logic signed [COEF_W-1:0] coef1_im;
    logic signed [COEF_W-1:0] coef2_re;
    logic signed [COEF_W-1:0] coef2_im;
    logic signed [COEF_W-1:0] coef3_re;
    logic signed [COEF_W-1:0] coef3_im;

    modport source
    (
        output valid, action, gain_antenna, gain_polarization,
        output coef0_re, coef0_im, coef1_re, coef1_im,
        output coef2_re, coef2_im, coef3_re, coef3_im,
        input  ready
    );

    modport sink
    (
        input  valid, action, gain_antenna, gain_polarization,
        input  coef0_re, coef0_im, coef1_re, coef1_im,
        input  coef2_re, coef2_im, coef3_re, coef3_im,
        output ready
    );

endinterface

// ===== rtl/cgrdp_out_if.sv =====
interface cgrdp_out_if;
    import cgrdp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [SUM_OUT_W-1:0] sum_re;
    logic signed [SUM_OUT_W-1:0] sum_im;
    logic [FIELD_ANT_W-1:0]      antenna_index;
    logic                        last_of_vector;

    modport source
    (
        output valid, sum_re, sum_im, antenna_index, last_of_vector,
        input  ready
    );

    modport sink
    (
        input  valid, sum_re, sum_im, antenna_index, last_of_vector,
        output ready
    );

endinterface

// ===== rtl/cgrdp_ram.sv =====
module cgrdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cgrdp_cfg.sv =====
module cgrdp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cgrdp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cgrdp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cgrdp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output cgrdp_pkg::geom_t                 geom
);
    import cgrdp_pkg::*;

    logic [CFG_NA_W-1:0]    na_reg;
    logic [CFG_NT_W-1:0]    nt_reg;
    logic [CFG_NA_W-1:0]    na_c;
    logic [CFG_NT_W-1:0]    nt_c;
    logic [CFG_NA_W-1:0]    na_m1;
    logic [GEOM_PROD_W-1:0] prod;
    reg_idx_t               idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            na_reg <= CFG_NA_W'(2);
            nt_reg <= CFG_NT_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ANTENNAS:  na_reg <= pwdata[CFG_NA_W-1:0];
                REG_TIMESTEPS: nt_reg <= pwdata[CFG_NT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ANTENNAS:  prdata = CFG_DATA_W'(na_reg);
            REG_TIMESTEPS: prdata = CFG_DATA_W'(nt_reg);
            default:       prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped where they are used.
    always_comb
    begin
        if (na_reg < CFG_NA_W'(2))
        begin
            na_c = CFG_NA_W'(2);
        end
        else if (int'(na_reg) > MAX_ANTENNAS)
        begin
            na_c = CFG_NA_W'(MAX_ANTENNAS);
        end
        else
        begin
            na_c = na_reg;
        end

        if (nt_reg == '0)
        begin
            nt_c = CFG_NT_W'(1);
        end
        else if (int'(nt_reg) > MAX_TIMESTEPS)
        begin
            nt_c = CFG_NT_W'(MAX_TIMESTEPS);
        end
        else
        begin
            nt_c = nt_reg;
        end

        na_m1     = na_c - CFG_NA_W'(1);
        prod      = GEOM_PROD_W'(na_m1) * GEOM_PROD_W'(nt_c);
        geom.na   = na_c;
        geom.rows = ROW_W'({prod, POL_W'(0)});
    end

endmodule

// ===== rtl/cgrdp_ctrl.sv =====
module cgrdp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cgrdp_pkg::geom_t    geom,
    output cgrdp_pkg::row_tag_t tag
);
    import cgrdp_pkg::*;

    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [ANT_W-1:0]    ant_reg;
    logic [ANT_W-1:0]    ant_next;
    logic [ANT_W-1:0]    ant_eff;
    logic [ROW_W:0]      row_inc;
    logic [CFG_NA_W:0]   ant_inc;
    logic                end_ant;
    logic                last_ant;

    always_comb
    begin
        ant_eff  = (int'(ant_reg) >= MAX_ANTENNAS) ? '0 : ant_reg;
        row_inc  = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
        end_ant  = row_inc >= (ROW_W+1)'(geom.rows);
        ant_inc  = (CFG_NA_W+1)'(ant_eff) + (CFG_NA_W+1)'(1);
        last_ant = ant_inc >= (CFG_NA_W+1)'(geom.na);

        tag.antenna = ant_eff;
        tag.last    = end_ant && last_ant;

        row_next = row_reg;
        ant_next = ant_reg;
        if (step)
        begin
            if (end_ant)
            begin
                row_next = '0;
                ant_next = last_ant ? '0 : ANT_W'(ant_inc);
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
                ant_next = ant_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            ant_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            ant_reg <= ant_next;
        end
    end

endmodule

// ===== rtl/cgrdp_dp.sv =====
module cgrdp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_row,
    input  cgrdp_pkg::lanes_t   coef,
    input  cgrdp_pkg::row_tag_t tag,
    input  cgrdp_pkg::lanes_t   gain,
    output logic                advance,
    cgrdp_out_if.source         out_ch
);
    import cgrdp_pkg::*;

    logic en1;
    logic en2;
    logic en3;
    logic en_o;

    logic     v1_reg;
    lanes_t   coef1_reg;
    row_tag_t tag1_reg;

    logic                     v2_reg;
    logic signed [PROD_W-1:0] p_rr_reg [POLARIZATIONS];
    logic signed [PROD_W-1:0] p_ii_reg [POLARIZATIONS];
    logic signed [PROD_W-1:0] p_ri_reg [POLARIZATIONS];
    logic signed [PROD_W-1:0] p_ir_reg [POLARIZATIONS];
    row_tag_t                 tag2_reg;

    logic                     v3_reg;
    logic signed [LANE_W-1:0] lane_re_reg [POLARIZATIONS];
    logic signed [LANE_W-1:0] lane_im_reg [POLARIZATIONS];
    row_tag_t                 tag3_reg;

    logic                        out_v_reg;
    logic signed [SUM_OUT_W-1:0] sum_re_reg;
    logic signed [SUM_OUT_W-1:0] sum_im_reg;
    row_tag_t                    tag_o_reg;

    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;

    // Each stage moves on when it is empty or the stage after it moves on.
    assign en_o    = !out_v_reg || out_ch.ready;
    assign en3     = !v3_reg || en_o;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign advance = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= load_row;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_o)
            begin
                out_v_reg <= v3_reg;
            end
        end
    end

    // The gain read issued with the accepted row lands alongside stage 1.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            coef1_reg <= coef;
            tag1_reg  <= tag;
        end
        if (en2)
        begin
            for (int l = 0; l < POLARIZATIONS; l++)
            begin
                p_rr_reg[l] <= coef1_reg[l].re * gain[l].re;
                p_ii_reg[l] <= coef1_reg[l].im * gain[l].im;
                p_ri_reg[l] <= coef1_reg[l].re * gain[l].im;
                p_ir_reg[l] <= coef1_reg[l].im * gain[l].re;
            end
            tag2_reg <= tag1_reg;
        end
        if (en3)
        begin
            for (int l = 0; l < POLARIZATIONS; l++)
            begin
                lane_re_reg[l] <= LANE_W'(p_rr_reg[l]) - LANE_W'(p_ii_reg[l]);
                lane_im_reg[l] <= LANE_W'(p_ri_reg[l]) + LANE_W'(p_ir_reg[l]);
            end
            tag3_reg <= tag2_reg;
        end
        if (en_o)
        begin
            sum_re_reg <= acc_re[FRAC_BITS+SUM_OUT_W-1:FRAC_BITS];
            sum_im_reg <= acc_im[FRAC_BITS+SUM_OUT_W-1:FRAC_BITS];
            tag_o_reg  <= tag3_reg;
        end
    end

    // Exact four-lane total plus half an LSB; the upper bits are the rounded Q4.15.
    always_comb
    begin
        acc_re = ROUND_BIAS;
        acc_im = ROUND_BIAS;
        for (int l = 0; l < POLARIZATIONS; l++)
        begin
            acc_re = acc_re + ACC_W'(lane_re_reg[l]);
            acc_im = acc_im + ACC_W'(lane_im_reg[l]);
        end
    end

    assign out_ch.valid          = out_v_reg;
    assign out_ch.sum_re         = sum_re_reg;
    assign out_ch.sum_im         = sum_im_reg;
    assign out_ch.antenna_index  = FIELD_ANT_W'(tag_o_reg.antenna);
    assign out_ch.last_of_vector = tag_o_reg.last;

endmodule

// ===== rtl/complex_gain_row_dot_product_top.sv =====
// Channel   Role            Transaction
// in_ch     sink            one gain load or one four-lane Jacobian row
// out_ch    source          one rounded complex sum per row
// APB       slave           antennas_in_use at 0x0, timesteps_in_use at 0x4
//
// One row is accepted per cycle while no stall holds the stages; each accepted row passes
// through the gain read, products, lane sums and output register in turn.
// The gain store is four memories, one per polarization, read together at the
// current antenna; it has no reset and must be loaded before it is used.
// A stalled output backs up stage by stage; input is refused only when every
// stage holds an item.
`include "complex_gain_row_dot_product_top_assert.svh"

module complex_gain_row_dot_product_top (
    input  logic                             clk,
    input  logic                             rst_n,
    cgrdp_in_if.sink                         in_ch,
    cgrdp_out_if.source                      out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cgrdp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cgrdp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cgrdp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import cgrdp_pkg::*;

    geom_t            geom;
    row_tag_t         tag;
    lanes_t           coef;
    lanes_t           gain;
    cplx_t            gain_wdata;
    logic             advance;
    logic             in_acc;
    logic             cmp_acc;
    logic             load_ok;
    logic [ANT_W-1:0] load_addr;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cmp_acc = in_acc && (in_ch.action == ACT_COMPUTE);
    // Loads for antennas beyond the store are dropped.
    assign load_ok = in_acc && (in_ch.action == ACT_LOAD)
                     && (int'(in_ch.gain_antenna) < MAX_ANTENNAS);
    assign load_addr   = ANT_W'(in_ch.gain_antenna);
    assign in_ch.ready = advance;

    assign gain_wdata.re = in_ch.coef0_re;
    assign gain_wdata.im = in_ch.coef0_im;

    assign coef[0].re = in_ch.coef0_re;
    assign coef[0].im = in_ch.coef0_im;
    assign coef[1].re = in_ch.coef1_re;
    assign coef[1].im = in_ch.coef1_im;
    assign coef[2].re = in_ch.coef2_re;
    assign coef[2].im = in_ch.coef2_im;
    assign coef[3].re = in_ch.coef3_re;
    assign coef[3].im = in_ch.coef3_im;

    cgrdp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    cgrdp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (cmp_acc),
        .geom  (geom),
        .tag   (tag)
    );

    for (genvar p = 0; p < POLARIZATIONS; p++)
    begin : g_gain
        logic we;

        assign we = load_ok && (int'(in_ch.gain_polarization) == p);

        cgrdp_ram #(
            .WIDTH ($bits(cplx_t)),
            .DEPTH (MAX_ANTENNAS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (load_addr),
            .wdata (gain_wdata),
            .re    (advance),
            .raddr (tag.antenna),
            .rdata (gain[p])
        );
    end

    cgrdp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_row (cmp_acc),
        .coef     (coef),
        .tag      (tag),
        .gain     (gain),
        .advance  (advance),
        .out_ch   (out_ch)
    );

    // After the final row of the vector the walk starts again at antenna zero.
    `CGRDP_ASSERT_NEXT(a_wrap_to_first, cmp_acc && tag.last, tag.antenna == '0)
    // Input is only refused when a finished result is waiting at the output.
    `CGRDP_ASSERT_NOW(a_stall_from_out, !in_ch.ready, out_ch.valid && !out_ch.ready)

endmodule
